[src/ppt_pkg.sv]
// Shared types, constants and register indexes of the projective point transform.
package ppt_pkg;

    localparam int OUT_W           = 48;
    localparam int FRAC_BITS       = 16;
    localparam int COEF_W          = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 3;
    localparam int NUM_ROWS        = 3;
    localparam int DEF_COORD_WIDTH = 16;
    localparam int Q_DEPTH         = 4;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int NUM_W           = OUT_W + FRAC_BITS;
    localparam int DIV_STEPS       = NUM_W;

    localparam logic signed [OUT_W-1:0] ONE_FIX = OUT_W'(64'sd65536);
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Reset values: identity matrix, bypass and divide on.
    localparam logic [CFG_DATA_W-1:0] RST_ROW0_XY  = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW1_XY  = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW2_XY  = 64'h0000_0000_0000_0000;
    localparam logic [COEF_W-1:0]     RST_ROW0_OFF = 32'h0000_0000;
    localparam logic [COEF_W-1:0]     RST_ROW1_OFF = 32'h0000_0000;
    localparam logic [COEF_W-1:0]     RST_ROW2_OFF = 32'h0001_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROW0_XY  = 3'd0,
        CFG_ROW0_OFF = 3'd1,
        CFG_ROW1_XY  = 3'd2,
        CFG_ROW1_OFF = 3'd3,
        CFG_ROW2_XY  = 3'd4,
        CFG_ROW2_OFF = 3'd5,
        CFG_BYPASS   = 3'd6,
        CFG_DIV_EN   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_ROWS-1:0][CFG_DATA_W-1:0] xy;
        logic [NUM_ROWS-1:0][COEF_W-1:0]     off;
        logic                                bypass;
        logic                                div_en;
    } t_cfg;

    // One classified item between the front and the back.
    typedef struct packed {
        logic                    div;
        logic                    vres;
        logic                    aff;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] w;
    } t_qent;

    // One stage of the divider pipeline; quotient bits shift into num.
    typedef struct packed {
        logic             valid;
        logic             div;
        logic             vres;
        logic             aff;
        logic             negx;
        logic             negy;
        logic [OUT_W-1:0] den;
        logic [OUT_W-1:0] remx;
        logic [OUT_W-1:0] remy;
        logic [NUM_W-1:0] numx;
        logic [NUM_W-1:0] numy;
    } t_dstage;

endpackage

[src/ppt_cfg.sv]
// Configuration register file of the projective point transform.
module ppt_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ppt_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output ppt_pkg::t_cfg                    o_cfg
);

    ppt_pkg::t_cfg r_cfg;

    // Register writes; every index of the address space is a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xy[0]  <= ppt_pkg::RST_ROW0_XY;
            r_cfg.xy[1]  <= ppt_pkg::RST_ROW1_XY;
            r_cfg.xy[2]  <= ppt_pkg::RST_ROW2_XY;
            r_cfg.off[0] <= ppt_pkg::RST_ROW0_OFF;
            r_cfg.off[1] <= ppt_pkg::RST_ROW1_OFF;
            r_cfg.off[2] <= ppt_pkg::RST_ROW2_OFF;
            r_cfg.bypass <= 1'b1;
            r_cfg.div_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (ppt_pkg::t_cfg_idx'(i_cfg_addr))
                ppt_pkg::CFG_ROW0_XY:  r_cfg.xy[0]  <= i_cfg_wdata;
                ppt_pkg::CFG_ROW0_OFF: r_cfg.off[0] <= i_cfg_wdata[ppt_pkg::COEF_W-1:0];
                ppt_pkg::CFG_ROW1_XY:  r_cfg.xy[1]  <= i_cfg_wdata;
                ppt_pkg::CFG_ROW1_OFF: r_cfg.off[1] <= i_cfg_wdata[ppt_pkg::COEF_W-1:0];
                ppt_pkg::CFG_ROW2_XY:  r_cfg.xy[2]  <= i_cfg_wdata;
                ppt_pkg::CFG_ROW2_OFF: r_cfg.off[2] <= i_cfg_wdata[ppt_pkg::COEF_W-1:0];
                ppt_pkg::CFG_BYPASS:   r_cfg.bypass <= i_cfg_wdata[0];
                ppt_pkg::CFG_DIV_EN:   r_cfg.div_en <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/ppt_front.sv]
// Front end: input register, matrix multiply, row sums and item classification.
module ppt_front #(
    parameter int COORD_WIDTH = ppt_pkg::DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppt_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic                          i_q_full,
    output logic                          o_push,
    output ppt_pkg::t_qent                o_ent
);

    localparam int PROD_W = ppt_pkg::COEF_W + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int EXT_W  = (SUM_W > ppt_pkg::OUT_W) ? SUM_W : ppt_pkg::OUT_W + 1;
    localparam int OW     = ppt_pkg::OUT_W;

    // Saturate a wide signed sum to the output range.
    function automatic logic signed [OW-1:0] sat_out(input logic signed [EXT_W-1:0] v);
        logic [EXT_W-OW:0] top;
        top = v[EXT_W-1:OW-1];
        if ((&top) || !(|top)) begin
            return v[OW-1:0];
        end
        return v[EXT_W-1] ? ppt_pkg::OUT_MIN : ppt_pkg::OUT_MAX;
    endfunction

    logic                          en;
    logic                          r_a_valid, r_b_valid, r_c_valid;
    logic signed [COORD_WIDTH-1:0] r_a_x, r_a_y, r_b_x, r_b_y;
    logic signed [PROD_W-1:0]      r_px [ppt_pkg::NUM_ROWS];
    logic signed [PROD_W-1:0]      r_py [ppt_pkg::NUM_ROWS];
    logic signed [OW-1:0]          sums [ppt_pkg::NUM_ROWS];
    logic signed [OW-1:0]          xb, yb;
    logic                          zero_w, row2_zero;
    ppt_pkg::t_qent                n_ent, r_ent;

    // The whole front advances unless a finished item waits on a full queue.
    assign en      = !(r_c_valid && i_q_full);
    assign o_ready = en;
    assign o_push  = r_c_valid && !i_q_full;
    assign o_ent   = r_ent;

    // Valid bits of the three front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Input registers and one 32 by COORD_WIDTH product per coefficient.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x <= i_x;
            r_a_y <= i_y;
            r_b_x <= r_a_x;
            r_b_y <= r_a_y;
            for (int r = 0; r < ppt_pkg::NUM_ROWS; r++) begin
                r_px[r] <= $signed(i_cfg.xy[r][ppt_pkg::COEF_W-1:0]) * r_a_x;
                r_py[r] <= $signed(i_cfg.xy[r][2*ppt_pkg::COEF_W-1:ppt_pkg::COEF_W]) * r_a_y;
            end
            r_ent <= n_ent;
        end
    end

    // Exact row sums, then saturation and classification.
    always_comb begin
        for (int r = 0; r < ppt_pkg::NUM_ROWS; r++) begin
            sums[r] = sat_out(EXT_W'(r_px[r]) + EXT_W'(r_py[r])
                              + EXT_W'($signed(i_cfg.off[r])));
        end
        xb        = OW'($signed({r_b_x, {ppt_pkg::FRAC_BITS{1'b0}}}));
        yb        = OW'($signed({r_b_y, {ppt_pkg::FRAC_BITS{1'b0}}}));
        zero_w    = (sums[2] == '0);
        row2_zero = (i_cfg.xy[2] == '0);
        if (i_cfg.bypass) begin
            n_ent.div  = 1'b0;
            n_ent.vres = 1'b1;
            n_ent.aff  = 1'b1;
            n_ent.x    = xb;
            n_ent.y    = yb;
            n_ent.w    = ppt_pkg::ONE_FIX;
        end else begin
            n_ent.div  = !zero_w && i_cfg.div_en;
            n_ent.vres = !zero_w;
            n_ent.aff  = row2_zero;
            n_ent.x    = zero_w ? '0 : sums[0];
            n_ent.y    = zero_w ? '0 : sums[1];
            n_ent.w    = sums[2];
        end
    end

endmodule

[src/ppt_queue.sv]
// Short queue that decouples the front end from the divider back end.
module ppt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppt_pkg::t_qent i_ent,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ppt_pkg::t_qent o_ent
);

    localparam int PW = ppt_pkg::Q_PTR_W;

    ppt_pkg::t_qent r_mem [ppt_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(ppt_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_ent   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

endmodule

[src/ppt_back.sv]
// Back end: pipelined restoring divider for x/w and y/w, and the output register.
module ppt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  ppt_pkg::t_qent                i_ent,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_vres,
    output logic                          o_aff,
    output logic [ppt_pkg::OUT_W-1:0]     o_x,
    output logic [ppt_pkg::OUT_W-1:0]     o_y,
    output logic [ppt_pkg::OUT_W-1:0]     o_w
);

    localparam int OW = ppt_pkg::OUT_W;
    localparam int NW = ppt_pkg::NUM_W;
    localparam int ST = ppt_pkg::DIV_STEPS;

    // Magnitude of a signed value.
    function automatic logic [OW-1:0] mag(input logic signed [OW-1:0] v);
        return v[OW-1] ? OW'(-v) : v;
    endfunction

    // One restoring step; the quotient bit enters at the bottom of num.
    function automatic void div_step(input logic [OW-1:0] rem, input logic [NW-1:0] num,
                                     input logic [OW-1:0] den,
                                     output logic [OW-1:0] rem_o,
                                     output logic [NW-1:0] num_o);
        logic [OW:0] t;
        logic [OW:0] d;
        logic        ge;
        t     = {rem, num[NW-1]};
        d     = {1'b0, den};
        ge    = (t >= d);
        rem_o = ge ? OW'(t - d) : t[OW-1:0];
        num_o = {num[NW-2:0], ge};
    endfunction

    // Apply the sign and saturate a quotient to the output range.
    function automatic logic [OW-1:0] fin(input logic [NW-1:0] q, input logic neg);
        if (neg) begin
            if (q > NW'(ppt_pkg::OUT_MAX) + NW'(1)) begin
                return ppt_pkg::OUT_MIN;
            end
            return OW'(-q[OW-1:0]);
        end
        if (q > NW'(ppt_pkg::OUT_MAX)) begin
            return ppt_pkg::OUT_MAX;
        end
        return q[OW-1:0];
    endfunction

    logic              en;
    ppt_pkg::t_dstage  r_st [ST+1];
    ppt_pkg::t_dstage  n_prep;
    ppt_pkg::t_dstage  last;
    logic              r_out_valid;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_q_empty;
    assign last  = r_st[ST];

    // Prepare operands: magnitudes and signs for division, raw values otherwise.
    always_comb begin
        n_prep.valid = !i_q_empty;
        n_prep.div   = i_ent.div;
        n_prep.vres  = i_ent.vres;
        n_prep.aff   = i_ent.aff;
        n_prep.negx  = i_ent.x[OW-1] ^ i_ent.w[OW-1];
        n_prep.negy  = i_ent.y[OW-1] ^ i_ent.w[OW-1];
        n_prep.remx  = '0;
        n_prep.remy  = '0;
        if (i_ent.div) begin
            n_prep.den  = mag(i_ent.w);
            n_prep.numx = {mag(i_ent.x), {ppt_pkg::FRAC_BITS{1'b0}}};
            n_prep.numy = {mag(i_ent.y), {ppt_pkg::FRAC_BITS{1'b0}}};
        end else begin
            n_prep.den  = i_ent.w;
            n_prep.numx = NW'(i_ent.x);
            n_prep.numy = NW'(i_ent.y);
        end
    end

    // Operand stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].valid <= 1'b0;
        end else if (en) begin
            r_st[0] <= n_prep;
        end
    end

    // Divider stages, one quotient bit each; items that need no division hold.
    for (genvar i = 0; i < ST; i++) begin : g_div
        ppt_pkg::t_dstage n_st;
        always_comb begin
            n_st = r_st[i];
            if (r_st[i].div) begin
                div_step(r_st[i].remx, r_st[i].numx, r_st[i].den, n_st.remx, n_st.numx);
                div_step(r_st[i].remy, r_st[i].numy, r_st[i].den, n_st.remy, n_st.numy);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[i+1].valid <= 1'b0;
            end else if (en) begin
                r_st[i+1] <= n_st;
            end
        end
    end

    // Output register; it holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_vres <= last.vres;
            o_aff  <= last.aff;
            if (last.div) begin
                o_x <= fin(last.numx, last.negx);
                o_y <= fin(last.numy, last.negy);
                o_w <= ppt_pkg::ONE_FIX;
            end else begin
                o_x <= last.numx[OW-1:0];
                o_y <= last.numy[OW-1:0];
                o_w <= last.den;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

[src/projective_point_transform.sv]
// Top level of the 3x3 homogeneous projective point transform.
//
// Input words arrive on the s_axis channel: x_in and y_in, signed integers.
// Each word yields one result word on m_axis: x_out, y_out and w_out in
// signed 32.16, with valid_res and affine flags in tuser. The matrix, bypass
// and divide controls are written through the cfg port; the user writes them
// only while idle, which the block does not enforce. A write lands at the
// clock edge of i_cfg_we. Throughput is one word per cycle while m_axis
// does not stall. Words pass three front stages (input, 32-bit multiplies,
// saturated row sums), the queue, an operand stage, 64 restoring divider
// stages (one quotient bit each for x/w and y/w) and the output register.
// When m_axis stalls, the back pipeline holds; the four-entry queue keeps
// the front running until it fills, then s_axis_tready drops.
// Synchronous reset clears all valid bits and restores the identity
// matrix with bypass and divide on.
module projective_point_transform #(
    parameter int COORD_WIDTH = ppt_pkg::DEF_COORD_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // x_in, y_in from bit 0 up, zero padded to bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // x_out, y_out, w_out from bit 0 up
    output logic [3*ppt_pkg::OUT_W-1:0]          m_axis_tdata,
    // valid_res, affine from bit 0 up
    output logic [1:0]                           m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [ppt_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    ppt_pkg::t_cfg    cfg;
    ppt_pkg::t_qent   push_ent, head_ent;
    logic             push, q_full, pop, q_empty;
    logic             vres, aff;
    logic [ppt_pkg::OUT_W-1:0] xo, yo, wo;

    ppt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ppt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_x      ($signed(s_axis_tdata[COORD_WIDTH-1:0])),
        .i_y      ($signed(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .i_q_full (q_full),
        .o_push   (push),
        .o_ent    (push_ent)
    );

    ppt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_ent   (head_ent)
    );

    ppt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_ent     (head_ent),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_vres    (vres),
        .o_aff     (aff),
        .o_x       (xo),
        .o_y       (yo),
        .o_w       (wo)
    );

    assign m_axis_tdata = {wo, yo, xo};
    assign m_axis_tuser = {aff, vres};

endmodule

[src/ppt_checker.sv]
// Port-level checks of the projective point transform, bound to the top level.
module ppt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [3*ppt_pkg::OUT_W-1:0] m_axis_tdata,
    input logic [1:0]                  m_axis_tuser
);

    localparam int OW = ppt_pkg::OUT_W;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Reset empties the output.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A failed transform carries all-zero values.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("invalid result with nonzero values");

    // A zero w is reported only on a failed transform.
    a_zero_w_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3*OW-1:2*OW] == '0 |-> !m_axis_tuser[0])
        else $error("valid result with zero w");

endmodule

bind projective_point_transform ppt_checker u_ppt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[test/projective_point_transform_tb.sv]
// Testbench for the projective point transform: random and directed points checked in order.

// Holds the predicted transform results and checks each output word against them.
class point_scoreboard;
    typedef struct {
        logic                       vres;
        logic                       aff;
        logic signed [47:0]         x;
        logic signed [47:0]         y;
        logic signed [47:0]         w;
    } t_point_res;

    t_point_res pending[$];
    int unsigned mismatches;

    logic [63:0] row_xy[3];
    logic [31:0] row_off[3];
    logic        bypass;
    logic        div_en;

    function void reset_cfg();
        row_xy[0]  = ppt_pkg::RST_ROW0_XY;
        row_xy[1]  = ppt_pkg::RST_ROW1_XY;
        row_xy[2]  = ppt_pkg::RST_ROW2_XY;
        row_off[0] = ppt_pkg::RST_ROW0_OFF;
        row_off[1] = ppt_pkg::RST_ROW1_OFF;
        row_off[2] = ppt_pkg::RST_ROW2_OFF;
        bypass     = 1'b1;
        div_en     = 1'b1;
    endfunction

    function void write_cfg(ppt_pkg::t_cfg_idx idx, logic [63:0] val);
        case (idx)
            ppt_pkg::CFG_ROW0_XY:  row_xy[0] = val;
            ppt_pkg::CFG_ROW0_OFF: row_off[0] = val[31:0];
            ppt_pkg::CFG_ROW1_XY:  row_xy[1] = val;
            ppt_pkg::CFG_ROW1_OFF: row_off[1] = val[31:0];
            ppt_pkg::CFG_ROW2_XY:  row_xy[2] = val;
            ppt_pkg::CFG_ROW2_OFF: row_off[2] = val[31:0];
            ppt_pkg::CFG_BYPASS:   bypass = val[0];
            ppt_pkg::CFG_DIV_EN:   div_en = val[0];
            default: ;
        endcase
    endfunction

    // Saturate a wide value to the 48-bit output range.
    function logic signed [47:0] clamp48(logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < -128'sh8000_0000_0000) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    // Products fit easily in 128 bits, so the sum is exact before it is
    // clamped to 48 bits, like the saturated row sums of the front.
    function logic signed [47:0] row_value(int r, logic signed [15:0] x,
                                           logic signed [15:0] y);
        logic signed [127:0] s;
        s = 128'($signed(row_xy[r][31:0])) * 128'(x)
          + 128'($signed(row_xy[r][63:32])) * 128'(y)
          + 128'($signed(row_off[r]));
        return clamp48(s);
    endfunction

    // Fixed-point quotient truncated toward zero.
    function logic signed [47:0] quotient(logic signed [47:0] n, logic signed [47:0] d);
        logic signed [127:0] q;
        q = (128'(n) <<< 16) / 128'(d);
        return clamp48(q);
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y);
        t_point_res e;
        if (bypass) begin
            e.vres = 1'b1;
            e.aff  = 1'b1;
            e.x    = 48'(x) <<< 16;
            e.y    = 48'(y) <<< 16;
            e.w    = ppt_pkg::ONE_FIX;
        end else begin
            e.aff  = (row_xy[2] == 64'd0);
            e.vres = 1'b1;
            e.x    = row_value(0, x, y);
            e.y    = row_value(1, x, y);
            e.w    = row_value(2, x, y);
            if (e.w == 0) begin
                e.vres = 1'b0;
                e.x    = 0;
                e.y    = 0;
            end else if (div_en) begin
                e.x = quotient(e.x, e.w);
                e.y = quotient(e.y, e.w);
                e.w = ppt_pkg::ONE_FIX;
            end
        end
        pending.push_back(e);
    endfunction

    function void check_result(logic [143:0] data, logic [1:0] user);
        t_point_res e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected output word %h", data);
            return;
        end
        e = pending.pop_front();
        if (user[0] !== e.vres || user[1] !== e.aff || data[47:0] !== e.x
                || data[95:48] !== e.y || data[143:96] !== e.w) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: expected v=%b a=%b x=%h y=%h w=%h, got v=%b a=%b x=%h y=%h w=%h",
                         e.vres, e.aff, e.x, e.y, e.w, user[0], user[1],
                         data[47:0], data[95:48], data[143:96]);
        end
    endfunction
endclass

module projective_point_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // x_in, y_in from bit 0 up
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // x_out, y_out, w_out from bit 0 up
    logic [143:0] m_axis_tdata;
    // valid_res, affine from bit 0 up
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [63:0]  i_cfg_wdata = '0;

    point_scoreboard sb;
    int unsigned idle_cycles = 0;
    bit          sink_stalls = 1'b1;

    projective_point_transform DUT (.*);

    always #5 i_clk = ~i_clk;

    // Gap length: mostly short, sometimes long.
    function int unsigned gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Output side: check accepted words, stall at random.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : sink_ready
        int unsigned g;
        forever begin
            @(negedge i_clk);
            g = sink_stalls ? gap_len() : 0;
            if (g != 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The word stays valid after acceptance; the next send or drain decides what follows.
    task automatic send_point(logic [15:0] x, logic [15:0] y, bit gaps);
        int unsigned g;
        g = gaps ? gap_len() : 0;
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_point(x, y);
        @(negedge i_clk);
    endtask

    // Wait until every predicted result has arrived, then let the pipe drain.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(ppt_pkg::t_cfg_idx idx, logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_cfg(idx, val);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h0001_0000;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 32'h0003_FFFF) - 32'h0001_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_matrix(bit div);
        write_reg(ppt_pkg::CFG_ROW0_XY, {rand_coef(), rand_coef()});
        write_reg(ppt_pkg::CFG_ROW0_OFF, {32'd0, rand_coef()});
        write_reg(ppt_pkg::CFG_ROW1_XY, {rand_coef(), rand_coef()});
        write_reg(ppt_pkg::CFG_ROW1_OFF, {32'd0, rand_coef()});
        write_reg(ppt_pkg::CFG_ROW2_XY, ($urandom_range(0, 2) == 0) ? 64'd0
                                                    : {rand_coef(), rand_coef()});
        write_reg(ppt_pkg::CFG_ROW2_OFF, {32'd0, rand_coef()});
        write_reg(ppt_pkg::CFG_BYPASS, 64'd0);
        write_reg(ppt_pkg::CFG_DIV_EN, {63'd0, div});
    endtask

    initial begin
        sb = new();
        sb.reset_cfg();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: bypass with extreme coordinates.
        send_point(16'h8000, 16'h7FFF, 1'b0);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        send_point(16'h0000, 16'hFFFF, 1'b0);
        drain();

        // Zero w: all-zero third row.
        write_reg(ppt_pkg::CFG_BYPASS, 64'd0);
        write_reg(ppt_pkg::CFG_ROW2_OFF, 64'd0);
        send_point(16'd5, 16'd7, 1'b0);
        drain();

        // Quotient overflow: tiny w, large numerators; also raw sums.
        write_reg(ppt_pkg::CFG_ROW2_OFF, 64'd1);
        write_reg(ppt_pkg::CFG_ROW0_XY, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(ppt_pkg::CFG_ROW1_XY, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(ppt_pkg::CFG_ROW0_OFF, 64'h8000_0000);
        write_reg(ppt_pkg::CFG_ROW1_OFF, 64'h7FFF_FFFF);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h0001, 16'h0000, 1'b0);
        drain();
        write_reg(ppt_pkg::CFG_DIV_EN, 64'd0);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b0);
        drain();

        // Projective third row with positive w.
        write_reg(ppt_pkg::CFG_ROW2_XY, {32'hFFFF_0000, 32'h0000_8000});
        write_reg(ppt_pkg::CFG_DIV_EN, 64'd1);
        send_point(16'h0003, 16'hFFFD, 1'b0);
        send_point(16'h0002, 16'h0001, 1'b0);
        drain();

        // Random phases over varied settings.
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 5) begin
                write_reg(ppt_pkg::CFG_BYPASS, 64'd1);
            end else begin
                random_matrix(ph % 3 != 0);
            end
            sink_stalls = (ph != 7);
            for (int k = 0; k < 62; k++)
                send_point(rand_coord(), rand_coord(), ph != 7);
            drain();
        end

        repeat (100) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
